FILE: rtl/core/lls_pkg.sv
// Shared types, constants and helpers of the life-like grid step block.
`timescale 1ns / 1ps
`default_nettype none

package lls_pkg;

    localparam int MAX_WIDTH  = 64;
    localparam int MAX_HEIGHT = 64;
    localparam int ROW_BITS   = $clog2(MAX_HEIGHT);
    localparam int COL_BITS   = $clog2(MAX_WIDTH);
    localparam int DIM_BITS   = 7;
    localparam int MASK_BITS  = 9;
    localparam int WORD_BITS  = 2 * MAX_WIDTH;

    localparam logic [1:0] FUNC_WRITE = 2'd0;
    localparam logic [1:0] FUNC_READ  = 2'd1;
    localparam logic [1:0] FUNC_STEP  = 2'd2;

    localparam logic [1:0] CFG_GRID_WIDTH   = 2'd0;
    localparam logic [1:0] CFG_GRID_HEIGHT  = 2'd1;
    localparam logic [1:0] CFG_BIRTH_MASK   = 2'd2;
    localparam logic [1:0] CFG_SURVIVE_MASK = 2'd3;

    localparam logic [DIM_BITS-1:0]  RESET_WIDTH   = DIM_BITS'(64);
    localparam logic [DIM_BITS-1:0]  RESET_HEIGHT  = DIM_BITS'(64);
    localparam logic [MASK_BITS-1:0] RESET_BIRTH   = MASK_BITS'(8);
    localparam logic [MASK_BITS-1:0] RESET_SURVIVE = MASK_BITS'(12);

    typedef logic [MAX_WIDTH-1:0] row_t;

    typedef struct packed {
        logic [MASK_BITS-1:0] birth;
        logic [MASK_BITS-1:0] survive;
    } rule_cfg_t;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_CELL_RD,
        S_CELL_WR,
        S_GEN_RD,
        S_GEN_EX,
        S_RESP
    } state_t;

    // One bit per column, set for the columns inside the grid in use.
    function automatic row_t col_mask(input logic [DIM_BITS-1:0] width);
        row_t m;
        for (int c = 0; c < MAX_WIDTH; c++)
        begin
            m[c] = (c < int'(width));
        end
        return m;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/core/lls_ram.sv
// Generic synchronous RAM with one write port and one registered read port.
`timescale 1ns / 1ps
`default_nettype none

module lls_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

FILE: rtl/core/lls_rule.sv
// Next-state logic for one grid row from the rows above, at and below it.
`timescale 1ns / 1ps
`default_nettype none

module lls_rule
    import lls_pkg::*;
(
    input  wire row_t      up,
    input  wire row_t      mid,
    input  wire row_t      down,
    input  wire row_t      mid_vis,
    input  wire row_t      col_en,
    input  wire rule_cfg_t rules,
    output row_t           new_alive,
    output row_t           new_vis
);

    always_comb
    begin
        logic [MAX_WIDTH+1:0] ue;
        logic [MAX_WIDTH+1:0] me;
        logic [MAX_WIDTH+1:0] de;
        logic [3:0]           n;
        // Columns outside the grid, and the borders, read as dead neighbours.
        ue = {1'b0, up & col_en, 1'b0};
        me = {1'b0, mid & col_en, 1'b0};
        de = {1'b0, down & col_en, 1'b0};
        n  = '0;
        for (int c = 0; c < MAX_WIDTH; c++)
        begin
            n = 4'(ue[c]) + 4'(ue[c+1]) + 4'(ue[c+2])
              + 4'(me[c]) + 4'(me[c+2])
              + 4'(de[c]) + 4'(de[c+1]) + 4'(de[c+2]);
            if (col_en[c])
            begin
                new_alive[c] = mid[c] ? rules.survive[n] : rules.birth[n];
                new_vis[c]   = mid_vis[c] | (!mid[c] & rules.birth[n]);
            end
            else
            begin
                new_alive[c] = mid[c];
                new_vis[c]   = mid_vis[c];
            end
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/life_like_grid_step.sv
// Top level of the life-like grid step block: control, configuration and grid memory.
`timescale 1ns / 1ps
`default_nettype none

// The grid lives in one RAM word per row, alive bits and visited bits side by side.
// After reset a clearing pass writes every row once, before the first item is
// taken. A cell write is a read-modify-write of its row; a cell read only reads
// its row. A generation walks the rows in use, reading one row and then
// evaluating and writing back the row above it. An item that touches no cell of
// the grid goes straight to the response. A new item is taken as soon as the
// previous result sits in the output register.

module life_like_grid_step
    import lls_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_wen,
    input  wire logic [1:0]           cfg_index,
    input  wire logic [MASK_BITS-1:0] cfg_data,
    input  wire logic                 in_valid,
    output logic                      in_stall,
    input  wire logic [1:0]           func,
    input  wire logic [ROW_BITS-1:0]  row,
    input  wire logic [COL_BITS-1:0]  col,
    input  wire logic                 alive_in,
    output logic                      out_valid,
    input  wire logic                 out_stall,
    output logic                      alive_out,
    output logic                      visited_out
);

    state_t state_reg, state_next;

    logic [DIM_BITS-1:0]  grid_width_reg, grid_height_reg;
    logic [MASK_BITS-1:0] birth_mask_reg, survive_mask_reg;

    logic [1:0]          func_reg, func_next;
    logic [ROW_BITS-1:0] row_reg, row_next;
    logic [COL_BITS-1:0] col_reg, col_next;
    logic                alive_reg, alive_next;
    logic [DIM_BITS-1:0] rd_row_reg, rd_row_next;
    logic [ROW_BITS-1:0] clr_row_reg, clr_row_next;
    row_t                prev_reg, prev_next;
    row_t                cur_reg, cur_next;
    row_t                cur_vis_reg, cur_vis_next;
    logic                res_alive_reg, res_alive_next;
    logic                res_vis_reg, res_vis_next;
    logic                out_valid_reg, out_valid_next;
    logic                alive_out_reg, alive_out_next;
    logic                visited_out_reg, visited_out_next;

    logic [DIM_BITS-1:0]  used_w, used_h;
    row_t                 col_en;
    logic                 accept;
    logic                 in_grid;
    logic                 empty;
    logic                 out_free;
    logic [DIM_BITS-1:0]  wr_row;
    logic                 rd_in_grid;

    logic                 ram_we;
    logic [ROW_BITS-1:0]  ram_waddr, ram_raddr;
    logic [WORD_BITS-1:0] ram_wdata, ram_rdata;
    row_t                 rd_alive, rd_vis;
    row_t                 down_row, down_vis;
    row_t                 gen_alive, gen_vis;
    row_t                 cell_alive, cell_vis;
    rule_cfg_t            rules;

    assign used_w   = (grid_width_reg > DIM_BITS'(MAX_WIDTH)) ? DIM_BITS'(MAX_WIDTH)
                                                              : grid_width_reg;
    assign used_h   = (grid_height_reg > DIM_BITS'(MAX_HEIGHT)) ? DIM_BITS'(MAX_HEIGHT)
                                                                : grid_height_reg;
    assign col_en   = col_mask(used_w);
    assign empty    = (used_w == '0) || (used_h == '0);
    assign in_grid  = ({1'b0, row} < used_h) && ({1'b0, col} < used_w);
    assign accept   = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;
    assign wr_row   = rd_row_reg - DIM_BITS'(1);
    assign rd_in_grid = rd_row_reg < used_h;

    assign rd_alive = ram_rdata[MAX_WIDTH-1:0];
    assign rd_vis   = ram_rdata[WORD_BITS-1:MAX_WIDTH];
    // Rows below the grid in use count as dead.
    assign down_row = rd_in_grid ? rd_alive : '0;
    assign down_vis = rd_in_grid ? rd_vis : '0;

    assign rules.birth   = birth_mask_reg;
    assign rules.survive = survive_mask_reg;

    lls_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (MAX_HEIGHT)
    ) u_grid (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    lls_rule u_rule (
        .up        (prev_reg),
        .mid       (cur_reg),
        .down      (down_row),
        .mid_vis   (cur_vis_reg),
        .col_en    (col_en),
        .rules     (rules),
        .new_alive (gen_alive),
        .new_vis   (gen_vis)
    );

    always_comb
    begin
        cell_alive = rd_alive;
        cell_vis   = rd_vis;
        cell_alive[col_reg] = alive_reg;
        cell_vis[col_reg]   = rd_vis[col_reg] | alive_reg;
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_CLEAR:
            begin
                if (clr_row_reg == ROW_BITS'(MAX_HEIGHT - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    if ((func == FUNC_WRITE || func == FUNC_READ) && in_grid)
                    begin
                        state_next = S_CELL_RD;
                    end
                    else if (func == FUNC_STEP && !empty)
                    begin
                        state_next = S_GEN_RD;
                    end
                    else
                    begin
                        state_next = S_RESP;
                    end
                end
            end
            S_CELL_RD: state_next = S_CELL_WR;
            S_CELL_WR: state_next = S_RESP;
            S_GEN_RD:  state_next = S_GEN_EX;
            S_GEN_EX:
            begin
                if (rd_row_reg != '0 && rd_row_reg == used_h)
                begin
                    state_next = S_RESP;
                end
                else
                begin
                    state_next = S_GEN_RD;
                end
            end
            S_RESP:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Outputs and datapath.
    always_comb
    begin
        in_stall         = (state_reg != S_IDLE);
        func_next        = func_reg;
        row_next         = row_reg;
        col_next         = col_reg;
        alive_next       = alive_reg;
        rd_row_next      = rd_row_reg;
        clr_row_next     = clr_row_reg;
        prev_next        = prev_reg;
        cur_next         = cur_reg;
        cur_vis_next     = cur_vis_reg;
        res_alive_next   = res_alive_reg;
        res_vis_next     = res_vis_reg;
        alive_out_next   = alive_out_reg;
        visited_out_next = visited_out_reg;
        out_valid_next   = out_valid_reg && out_stall;
        ram_we           = 1'b0;
        ram_waddr        = row_reg;
        ram_wdata        = {cell_vis, cell_alive};
        ram_raddr        = row_reg;
        case (state_reg)
            S_CLEAR:
            begin
                ram_we       = 1'b1;
                ram_waddr    = clr_row_reg;
                ram_wdata    = '0;
                clr_row_next = clr_row_reg + ROW_BITS'(1);
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    func_next      = func;
                    row_next       = row;
                    col_next       = col;
                    alive_next     = alive_in;
                    rd_row_next    = '0;
                    res_alive_next = 1'b0;
                    res_vis_next   = 1'b0;
                end
            end
            S_CELL_RD:
            begin
                ram_raddr = row_reg;
            end
            S_CELL_WR:
            begin
                if (func_reg == FUNC_WRITE)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = row_reg;
                    ram_wdata = {cell_vis, cell_alive};
                end
                else
                begin
                    res_alive_next = rd_alive[col_reg];
                    res_vis_next   = rd_vis[col_reg];
                end
            end
            S_GEN_RD:
            begin
                ram_raddr = rd_row_reg[ROW_BITS-1:0];
            end
            S_GEN_EX:
            begin
                // The first read only primes the row window; later ones also
                // write back the row above the one just read.
                if (rd_row_reg == '0)
                begin
                    prev_next    = '0;
                    cur_next     = rd_alive;
                    cur_vis_next = rd_vis;
                end
                else
                begin
                    ram_we       = 1'b1;
                    ram_waddr    = wr_row[ROW_BITS-1:0];
                    ram_wdata    = {gen_vis, gen_alive};
                    prev_next    = cur_reg;
                    cur_next     = down_row;
                    cur_vis_next = down_vis;
                end
                rd_row_next = rd_row_reg + DIM_BITS'(1);
            end
            S_RESP:
            begin
                if (out_free)
                begin
                    out_valid_next   = 1'b1;
                    alive_out_next   = res_alive_reg;
                    visited_out_next = res_vis_reg;
                end
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_CLEAR;
            clr_row_reg      <= '0;
            rd_row_reg       <= '0;
            out_valid_reg    <= 1'b0;
            grid_width_reg   <= RESET_WIDTH;
            grid_height_reg  <= RESET_HEIGHT;
            birth_mask_reg   <= RESET_BIRTH;
            survive_mask_reg <= RESET_SURVIVE;
        end
        else
        begin
            state_reg     <= state_next;
            clr_row_reg   <= clr_row_next;
            rd_row_reg    <= rd_row_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wen)
            begin
                case (cfg_index)
                    CFG_GRID_WIDTH:   grid_width_reg   <= cfg_data[DIM_BITS-1:0];
                    CFG_GRID_HEIGHT:  grid_height_reg  <= cfg_data[DIM_BITS-1:0];
                    CFG_BIRTH_MASK:   birth_mask_reg   <= cfg_data;
                    CFG_SURVIVE_MASK: survive_mask_reg <= cfg_data;
                    default:          ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        func_reg        <= func_next;
        row_reg         <= row_next;
        col_reg         <= col_next;
        alive_reg       <= alive_next;
        prev_reg        <= prev_next;
        cur_reg         <= cur_next;
        cur_vis_reg     <= cur_vis_next;
        res_alive_reg   <= res_alive_next;
        res_vis_reg     <= res_vis_next;
        alive_out_reg   <= alive_out_next;
        visited_out_reg <= visited_out_next;
    end

    assign out_valid   = out_valid_reg;
    assign alive_out   = alive_out_reg;
    assign visited_out = visited_out_reg;

endmodule

`default_nettype wire
